// ----- rtl/core/lkvc_pkg.sv -----
// lkvc_pkg: shared constants and request/response types for the LRU key-value cache.
`timescale 1ns / 1ps
package lkvc_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int AGE_W   = IDX_W;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int CAP_W   = 5;
	localparam int DATA_W  = 32;

	localparam logic [CAP_W-1:0]        CAP_RESET  = 5'd16;
	localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	typedef struct packed {
		logic                     opcode;
		logic signed [DATA_W-1:0] key;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic                     hit;
		logic signed [DATA_W-1:0] read_value;
	} rsp_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] key;
		logic signed [DATA_W-1:0] value;
		logic [AGE_W-1:0]         age;
	} entry_t;

endpackage

// ----- rtl/core/lru_key_value_cache.sv -----
// lru_key_value_cache: fully associative key-value store with LRU replacement.
//
// Usage:
//   A request (opcode get/put, key, value) enters on req/req_valid and is taken
//   when req_valid is high and req_stall is low. Each request gives exactly one
//   response on rsp/rsp_valid, taken when rsp_valid is high and rsp_stall is low.
//   Entries live in one RAM word each (key, value, recency rank). A request
//   sweeps the RAM once to search keys and find the victim or a free slot,
//   then, unless it is a get miss, sweeps again to write back recency ranks
//   and the new entry; these RAM port sweeps set how long a request takes.
//   One request is in flight at a time; a new one is taken while the previous
//   response still sits in the output register.
//   Capacity is written through capacity_we/capacity_wdata; the user must
//   write it only while idle, as the block itself does not enforce this.
//   It is clamped to 1..ENTRIES. Reset empties the store (valid bits and live
//   count cleared, capacity back to 16). A stalled receiver holds the
//   response; the block finishes the next request and then waits for the
//   output register.
`timescale 1ns / 1ps
module lru_key_value_cache (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  lkvc_pkg::req_t            req,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output lkvc_pkg::rsp_t            rsp,
	input  logic                      capacity_we,
	input  logic [lkvc_pkg::CAP_W-1:0] capacity_wdata
);
	import lkvc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_UPDATE = 4'b0100,
		S_DONE   = 4'b1000
	} state_t;

	state_t state_q;

	logic [CAP_W-1:0]   capacity_q;
	logic [ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]   live_q;
	logic [CNT_W-1:0]   cap_eff;
	req_t               req_q;

	logic [CNT_W-1:0] cnt_q;
	logic             v_s1;
	logic [IDX_W-1:0] idx_s1;

	// scan results
	logic                     hit_q, hit_n;
	logic [IDX_W-1:0]         hit_idx_q, hit_idx_n;
	logic [AGE_W-1:0]         hit_age_q, hit_age_n;
	logic signed [DATA_W-1:0] hit_val_q, hit_val_n;
	logic                     vic_any_q, vic_any_n;
	logic [IDX_W-1:0]         vic_idx_q, vic_idx_n;
	logic [AGE_W-1:0]         vic_age_q, vic_age_n;
	logic                     free_any_q, free_any_n;
	logic [IDX_W-1:0]         free_idx_q, free_idx_n;

	// update target
	logic [IDX_W-1:0]         tgt_idx_q;
	logic                     tgt_wv_q;
	logic [AGE_W-1:0]         tgt_age_q;
	logic signed [DATA_W-1:0] tgt_val_q;

	rsp_t rsp_pend_q;
	rsp_t rsp_q;
	logic rsp_valid_q;

	logic       ram_re;
	logic       ram_we;
	entry_t     ram_rdata;
	entry_t     ram_wdata;
	logic       entry_v;
	logic       last_s1;
	logic       req_take;
	logic       rsp_free;

	lkvc_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_s1),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (cnt_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	always_comb begin
		if (capacity_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (32'(capacity_q) > ENTRIES) begin
			cap_eff = CNT_W'(ENTRIES);
		end else begin
			cap_eff = CNT_W'(capacity_q);
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign ram_re  = ((state_q == S_SCAN) || (state_q == S_UPDATE)) &&
		(cnt_q < CNT_W'(ENTRIES));
	assign ram_we  = v_s1 && (state_q == S_UPDATE);
	assign entry_v = valid_q[idx_s1];
	assign last_s1 = v_s1 && (idx_s1 == IDX_W'(ENTRIES - 1));

	// search: first key match, oldest valid entry (lowest index on ties), first free slot
	always_comb begin
		hit_n      = hit_q;
		hit_idx_n  = hit_idx_q;
		hit_age_n  = hit_age_q;
		hit_val_n  = hit_val_q;
		vic_any_n  = vic_any_q;
		vic_idx_n  = vic_idx_q;
		vic_age_n  = vic_age_q;
		free_any_n = free_any_q;
		free_idx_n = free_idx_q;
		// a new request clears the search flags
		if (req_take) begin
			hit_n      = 1'b0;
			vic_any_n  = 1'b0;
			free_any_n = 1'b0;
		end
		if (v_s1 && (state_q == S_SCAN)) begin
			if (entry_v && (ram_rdata.key == req_q.key) && !hit_q) begin
				hit_n     = 1'b1;
				hit_idx_n = idx_s1;
				hit_age_n = ram_rdata.age;
				hit_val_n = ram_rdata.value;
			end
			if (entry_v && (!vic_any_q || (ram_rdata.age > vic_age_q))) begin
				vic_any_n = 1'b1;
				vic_idx_n = idx_s1;
				vic_age_n = ram_rdata.age;
			end
			if (!entry_v && !free_any_q) begin
				free_any_n = 1'b1;
				free_idx_n = idx_s1;
			end
		end
	end

	// write-back word: target takes the new entry at rank 0, younger entries age by one
	always_comb begin
		ram_wdata = ram_rdata;
		if (idx_s1 == tgt_idx_q) begin
			ram_wdata.key   = req_q.key;
			ram_wdata.value = tgt_val_q;
			ram_wdata.age   = '0;
		end else if (entry_v && (!tgt_wv_q || (ram_rdata.age < tgt_age_q))) begin
			ram_wdata.age = ram_rdata.age + AGE_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			capacity_q  <= CAP_RESET;
			valid_q     <= '0;
			live_q      <= '0;
			cnt_q       <= '0;
			v_s1        <= 1'b0;
			rsp_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			vic_any_q   <= 1'b0;
			free_any_q  <= 1'b0;
		end else begin
			if (capacity_we) begin
				capacity_q <= capacity_wdata;
			end

			v_s1 <= ram_re;
			if (ram_re) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end

			hit_q      <= hit_n;
			vic_any_q  <= vic_any_n;
			free_any_q <= free_any_n;

			if ((state_q == S_DONE) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req_take) begin
						cnt_q   <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (last_s1) begin
						cnt_q <= '0;
						if (hit_n) begin
							tgt_idx_q <= hit_idx_n;
							tgt_wv_q  <= 1'b1;
							tgt_age_q <= hit_age_n;
							tgt_val_q <= (req_q.opcode == OP_PUT) ? req_q.value : hit_val_n;
							rsp_pend_q.hit        <= 1'b1;
							rsp_pend_q.read_value <=
								(req_q.opcode == OP_PUT) ? req_q.value : hit_val_n;
							state_q <= S_UPDATE;
						end else if (req_q.opcode == OP_GET) begin
							rsp_pend_q.hit        <= 1'b0;
							rsp_pend_q.read_value <= MISS_VALUE;
							state_q <= S_DONE;
						end else begin
							rsp_pend_q.hit        <= 1'b0;
							rsp_pend_q.read_value <= req_q.value;
							tgt_val_q <= req_q.value;
							if (live_q >= cap_eff) begin
								tgt_idx_q <= vic_idx_n;
								tgt_wv_q  <= vic_any_n;
								tgt_age_q <= vic_age_n;
								valid_q[vic_idx_n] <= 1'b1;
								if (!vic_any_n) begin
									live_q <= CNT_W'(1);
								end
							end else begin
								tgt_idx_q <= free_idx_n;
								tgt_wv_q  <= 1'b0;
								tgt_age_q <= '0;
								valid_q[free_idx_n] <= 1'b1;
								live_q <= live_q + CNT_W'(1);
							end
							state_q <= S_UPDATE;
						end
					end
				end
				S_UPDATE: begin
					if (last_s1) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_free) begin
						rsp_q   <= rsp_pend_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[IDX_W-1:0];
		if (state_q == S_IDLE && req_take) begin
			req_q <= req;
		end
		hit_idx_q  <= hit_idx_n;
		hit_age_q  <= hit_age_n;
		hit_val_q  <= hit_val_n;
		vic_idx_q  <= vic_idx_n;
		vic_age_q  <= vic_age_n;
		free_idx_q <= free_idx_n;
	end

	// live count always tracks the number of valid entries
	a_live_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(live_q))
		else $error("live count differs from number of valid entries");

	a_live_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		int'(live_q) <= ENTRIES)
		else $error("live count above entry count");

	// RAM is written only during the write-back sweep
	a_write_in_update: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_UPDATE))
		else $error("RAM write outside update sweep");

	// a taken request always starts a search
	a_take_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		req_take |=> (state_q == S_SCAN) && (cnt_q == '0))
		else $error("accepted request did not start a scan");

endmodule

// ----- rtl/core/lkvc_ram.sv -----
// lkvc_ram: generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lkvc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- verif/tb_lru_key_value_cache.sv -----
// tb_lru_key_value_cache: self-checking testbench for the LRU key-value cache.
`timescale 1ns / 1ps
module tb_lru_key_value_cache;
	import lkvc_pkg::*;

	typedef enum logic {ROW_REQ, ROW_CAP} row_kind_t;

	typedef struct {
		row_kind_t kind;
		req_t      r;
		bit        pin;
		rsp_t      rsp;
	} stim_row_t;

	logic             clk;
	logic             arst_n;
	logic             req_valid;
	logic             req_stall;
	req_t             req;
	logic             rsp_valid;
	logic             rsp_stall;
	rsp_t             rsp;
	logic             capacity_we;
	logic [CAP_W-1:0] capacity_wdata;

	// shadow of the cache contents
	logic             slot_live [ENTRIES];
	logic [31:0]      slot_key  [ENTRIES];
	logic [31:0]      slot_val  [ENTRIES];
	int unsigned      slot_rank [ENTRIES];
	int unsigned      live_cnt;
	logic [CAP_W-1:0] cap_reg;

	rsp_t             pending_rsp [$];
	stim_row_t        dir_tab [$];
	bit               pinned;
	rsp_t             pinned_rsp;
	int               mismatch_cnt;
	int               gap_pct;
	int               stall_pct;
	int               hold_len;

	int ph_cap   [8] = '{16, 4, 1, 31, 0, 8, 17, 2};
	int ph_gap   [8] = '{0, 45, 0, 35, 0, 0, 35, 45};
	int ph_stall [8] = '{0, 0, 45, 35, 0, 0, 35, 0};
	int ph_cnt   [8] = '{200, 200, 150, 200, 100, 150, 200, 150};

	lru_key_value_cache dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.req            (req),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.rsp            (rsp),
		.capacity_we    (capacity_we),
		.capacity_wdata (capacity_wdata)
	);

	// Slot s becomes most recent; live entries younger than it age by one.
	function automatic void promote(int s, bit was_live);
		int unsigned r;
		r = slot_rank[s];
		for (int i = 0; i < ENTRIES; i++)
			if (i != s && slot_live[i] && (!was_live || slot_rank[i] < r))
				slot_rank[i]++;
		slot_rank[s] = 0;
	endfunction

	function automatic rsp_t cache_lookup(req_t r);
		rsp_t        o;
		int unsigned cap_eff;
		int          hit_slot;
		int          dst;
		int unsigned oldest;
		bit          any;
		cap_eff = (cap_reg == 0) ? 1 : (cap_reg > ENTRIES) ? ENTRIES : cap_reg;
		hit_slot = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (hit_slot < 0 && slot_live[i] && slot_key[i] == r.key)
				hit_slot = i;
		if (hit_slot >= 0) begin
			if (r.opcode == OP_PUT)
				slot_val[hit_slot] = r.value;
			promote(hit_slot, 1'b1);
			o.hit = 1'b1;
			o.read_value = slot_val[hit_slot];
			return o;
		end
		o.hit = 1'b0;
		if (r.opcode == OP_GET) begin
			o.read_value = MISS_VALUE;
			return o;
		end
		o.read_value = r.value;
		dst = 0;
		if (live_cnt >= cap_eff) begin
			// full (or capacity lowered): replace the least recent entry
			any = 1'b0;
			oldest = 0;
			for (int i = 0; i < ENTRIES; i++)
				if (slot_live[i] && (!any || slot_rank[i] > oldest)) begin
					oldest = slot_rank[i];
					dst = i;
					any = 1'b1;
				end
			promote(dst, any);
			if (!any)
				live_cnt = 1;
		end else begin
			for (int i = ENTRIES - 1; i >= 0; i--)
				if (!slot_live[i])
					dst = i;
			promote(dst, 1'b0);
			live_cnt++;
		end
		slot_key[dst] = r.key;
		slot_val[dst] = r.value;
		slot_live[dst] = 1'b1;
		return o;
	endfunction

	function automatic stim_row_t mk_row(row_kind_t k, logic op, logic [31:0] key,
			logic [31:0] val, bit pin, logic hit, logic [31:0] rv);
		stim_row_t s;
		s.kind = k;
		s.r.opcode = op;
		s.r.key = key;
		s.r.value = val;
		s.pin = pin;
		s.rsp.hit = hit;
		s.rsp.read_value = rv;
		return s;
	endfunction

	task automatic send_req(input req_t r, input bit pin, input rsp_t pin_rsp);
		while ($urandom_range(99) < gap_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		pinned <= pin;
		pinned_rsp <= pin_rsp;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic drain_rsp();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_capacity(input logic [CAP_W-1:0] v);
		drain_rsp();
		capacity_we <= 1'b1;
		capacity_wdata <= v;
		@(posedge clk);
		capacity_we <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver: random stall, or a counted hold-off when asked
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				rsp_stall <= 1'b1;
				hold_len--;
			end else
				rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (capacity_we)
				cap_reg = capacity_wdata;
			if (rsp_valid && !rsp_stall) begin
				if (pending_rsp.size() == 0) begin
					$error("unexpected response: hit=%0b read_value=%0d",
						rsp.hit, rsp.read_value);
					mismatch_cnt++;
				end else begin
					want = pending_rsp.pop_front();
					if (rsp.hit !== want.hit) begin
						$error("hit: expected %0b, got %0b", want.hit, rsp.hit);
						mismatch_cnt++;
					end
					if (rsp.read_value !== want.read_value) begin
						$error("read_value: expected %0d, got %0d",
							want.read_value, rsp.read_value);
						mismatch_cnt++;
					end
				end
			end
			if (req_valid && !req_stall) begin
				want = cache_lookup(req);
				if (pinned)
					want = pinned_rsp;
				pending_rsp.push_back(want);
			end
		end
	end

	initial begin
		#8_000_000;
		$display("tb_lru_key_value_cache: done, errors");
		$finish;
	end

	initial begin
		req_t        item;
		logic [31:0] key_pool [20];
		int          pool_n;
		int          eff;
		for (int i = 0; i < ENTRIES; i++) begin
			slot_live[i] = 1'b0;
			slot_key[i] = '0;
			slot_val[i] = '0;
			slot_rank[i] = 0;
		end
		live_cnt = 0;
		cap_reg = CAP_RESET;
		mismatch_cnt = 0;
		gap_pct = 0;
		stall_pct = 0;
		hold_len = 0;
		pinned = 1'b0;
		pinned_rsp = '0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		capacity_we = 1'b0;
		capacity_wdata = '0;

		// extremes of key and value; miss, insert, hit, update, near-miss key
		dir_tab.push_back(mk_row(ROW_REQ, OP_GET, 32'h0000_0000, 32'h0, 1'b1, 1'b0,
			MISS_VALUE));
		dir_tab.push_back(mk_row(ROW_REQ, OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0,
			32'h7FFF_FFFF));
		dir_tab.push_back(mk_row(ROW_REQ, OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0,
			32'h8000_0000));
		dir_tab.push_back(mk_row(ROW_REQ, OP_GET, 32'h8000_0000, 32'h0, 1'b1, 1'b1,
			32'h7FFF_FFFF));
		dir_tab.push_back(mk_row(ROW_REQ, OP_GET, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0,
			MISS_VALUE));
		dir_tab.push_back(mk_row(ROW_REQ, OP_PUT, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0, 32'h0));
		dir_tab.push_back(mk_row(ROW_REQ, OP_PUT, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1,
			32'hFFFF_FFFF));
		dir_tab.push_back(mk_row(ROW_REQ, OP_GET, 32'h7FFF_FFFE, 32'h0, 1'b1, 1'b0,
			MISS_VALUE));
		dir_tab.push_back(mk_row(ROW_REQ, OP_GET, 32'h7FFF_FFFF, 32'h0, 1'b1, 1'b1,
			32'h8000_0000));
		dir_tab.push_back(mk_row(ROW_REQ, OP_PUT, 32'h0000_0001, 32'h5A5A_5A5A, 1'b0, 1'b0,
			32'h0));
		// capacity dropped below the live count: puts replace, nothing dropped
		dir_tab.push_back(mk_row(ROW_CAP, OP_GET, 32'h0, 32'd2, 1'b0, 1'b0, 32'h0));
		dir_tab.push_back(mk_row(ROW_REQ, OP_PUT, 32'h0000_0002, 32'hA5A5_A5A5, 1'b0, 1'b0,
			32'h0));
		dir_tab.push_back(mk_row(ROW_REQ, OP_GET, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0, 32'h0));
		dir_tab.push_back(mk_row(ROW_REQ, OP_GET, 32'h8000_0000, 32'h0, 1'b0, 1'b0, 32'h0));
		// zero acts as one
		dir_tab.push_back(mk_row(ROW_CAP, OP_GET, 32'h0, 32'd0, 1'b0, 1'b0, 32'h0));
		dir_tab.push_back(mk_row(ROW_REQ, OP_PUT, 32'h0000_0003, 32'h3, 1'b0, 1'b0, 32'h0));
		dir_tab.push_back(mk_row(ROW_REQ, OP_PUT, 32'h0000_0004, 32'h4, 1'b0, 1'b0, 32'h0));
		dir_tab.push_back(mk_row(ROW_REQ, OP_GET, 32'h0000_0003, 32'h0, 1'b0, 1'b0, 32'h0));
		// above the entry count acts as full size
		dir_tab.push_back(mk_row(ROW_CAP, OP_GET, 32'h0, 32'd31, 1'b0, 1'b0, 32'h0));
		dir_tab.push_back(mk_row(ROW_REQ, OP_PUT, 32'h0000_0005, 32'h5, 1'b0, 1'b0, 32'h0));
		dir_tab.push_back(mk_row(ROW_REQ, OP_GET, 32'h8000_0000, 32'h0, 1'b0, 1'b0, 32'h0));
		dir_tab.push_back(mk_row(ROW_CAP, OP_GET, 32'h0, 32'd1, 1'b0, 1'b0, 32'h0));
		dir_tab.push_back(mk_row(ROW_REQ, OP_PUT, 32'h0000_0006, 32'h6, 1'b0, 1'b0, 32'h0));
		dir_tab.push_back(mk_row(ROW_REQ, OP_GET, 32'h0000_0006, 32'h0, 1'b0, 1'b0, 32'h0));
		dir_tab.push_back(mk_row(ROW_CAP, OP_GET, 32'h0, 32'd16, 1'b0, 1'b0, 32'h0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_CAP)
				set_capacity(dir_tab[i].r.value[CAP_W-1:0]);
			else
				send_req(dir_tab[i].r, dir_tab[i].pin, dir_tab[i].rsp);
		end

		for (int p = 0; p < 8; p++) begin
			set_capacity(CAP_W'(ph_cap[p]));
			gap_pct = ph_gap[p];
			stall_pct = ph_stall[p];
			eff = (ph_cap[p] == 0) ? 1 : (ph_cap[p] > ENTRIES) ? ENTRIES : ph_cap[p];
			// a pool a bit larger than the capacity gives both hits and evictions
			pool_n = eff + 3;
			for (int i = 0; i < pool_n; i++)
				key_pool[i] = $urandom();
			key_pool[0] = 32'h8000_0000;
			key_pool[pool_n-1] = 32'h7FFF_FFFF;
			if (p == 5)
				hold_len = 300;
			for (int n = 0; n < ph_cnt[p]; n++) begin
				if (p == 3 && n == ph_cnt[p] / 2)
					drain_rsp();
				item.opcode = $urandom_range(1) ? OP_PUT : OP_GET;
				item.key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(pool_n - 1)]
					: $urandom();
				item.value = $urandom();
				send_req(item, 1'b0, '0);
			end
		end

		drain_rsp();
		stall_pct = 0;
		repeat (40) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("tb_lru_key_value_cache: done, clean");
		else
			$display("tb_lru_key_value_cache: done, errors");
		$finish;
	end

endmodule

// ----- lru_key_value_cache.f -----
rtl/core/lkvc_pkg.sv
rtl/core/lkvc_ram.sv
rtl/core/lru_key_value_cache.sv
verif/tb_lru_key_value_cache.sv
